### hw/rtl/letter_frequency_rank_mapper_defines.svh
// Assertion macros shared by the letter frequency rank mapper RTL.
// The macros expect signals named clk and rst_n in the enclosing module.
`ifndef LETTER_FREQUENCY_RANK_MAPPER_DEFINES_SVH
`define LETTER_FREQUENCY_RANK_MAPPER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only out of reset.
`define LFRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define LFRM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LFRM_ASSERT(label, prop, msg)
`define LFRM_ASSERT_RST(label, prop, msg)
`endif

`endif

### hw/rtl/lfrm_pkg.sv
package lfrm_pkg;

  // ASCII code of the first letter of the alphabet.
  localparam logic [7:0] CODE_A = 8'h41;

  typedef enum logic [1:0] {
    REQ_TEXT   = 2'd0,
    REQ_TABLE  = 2'd1,
    REQ_FINISH = 2'd2
  } req_t;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_CNT_RD,
    OP_CNT_INC,
    OP_TAB_WR,
    OP_OUT_EMPTY,
    OP_CLEAR,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_ASSIGN,
    OP_EMIT_INIT,
    OP_EMIT_RD,
    OP_OUT_PAIR,
    OP_K_INC
  } dp_op_t;

  // Jump conditions; the jump is taken when the condition holds.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_NOT_TEXT,
    C_NOT_TABLE,
    C_NOT_FINISH,
    C_TAB_NONEMPTY,
    C_OUT_BUSY,
    C_SCAN_MORE,
    C_PICK_MORE,
    C_FLAG_CLEAR,
    C_EMIT_MORE
  } cond_t;

  // Microprogram steps, in program order.
  typedef enum logic [4:0] {
    S_IDLE,
    S_TXT_CHK,
    S_TXT_WR,
    S_TAB_CHK,
    S_TAB_WR,
    S_FIN_CHK,
    S_FIN_EMPTY,
    S_EMPTY_OUT,
    S_EMPTY_CLR,
    S_PICK_INIT,
    S_SCAN,
    S_ASSIGN,
    S_EMIT_INIT,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_EMIT_NEXT,
    S_DONE_CLR
  } step_t;

  typedef struct packed {
    logic   in_ready;
    dp_op_t op;
    cond_t  cond;
    step_t  target;
  } ctrl_word_t;

  // Datapath status that the sequencer tests for jumps.
  typedef struct packed {
    logic accept;
    logic is_text;
    logic is_table;
    logic is_finish;
    logic tab_nonempty;
    logic out_busy;
    logic scan_more;
    logic pick_more;
    logic flag_set;
    logic emit_more;
  } dp_status_t;

  // Control store. Each step either falls through to the next step or jumps.
  function automatic ctrl_word_t ucode_rom(step_t step);
    ctrl_word_t w;
    unique case (step)
      S_IDLE:      w = '{1'b1, OP_LATCH,     C_NO_ACCEPT,    S_IDLE};
      S_TXT_CHK:   w = '{1'b0, OP_CNT_RD,    C_NOT_TEXT,     S_TAB_CHK};
      S_TXT_WR:    w = '{1'b0, OP_CNT_INC,   C_ALWAYS,       S_IDLE};
      S_TAB_CHK:   w = '{1'b0, OP_NONE,      C_NOT_TABLE,    S_FIN_CHK};
      S_TAB_WR:    w = '{1'b0, OP_TAB_WR,    C_ALWAYS,       S_IDLE};
      S_FIN_CHK:   w = '{1'b0, OP_NONE,      C_NOT_FINISH,   S_IDLE};
      S_FIN_EMPTY: w = '{1'b0, OP_NONE,      C_TAB_NONEMPTY, S_PICK_INIT};
      S_EMPTY_OUT: w = '{1'b0, OP_OUT_EMPTY, C_OUT_BUSY,     S_EMPTY_OUT};
      S_EMPTY_CLR: w = '{1'b0, OP_CLEAR,     C_ALWAYS,       S_IDLE};
      S_PICK_INIT: w = '{1'b0, OP_SCAN_INIT, C_NEVER,        S_IDLE};
      S_SCAN:      w = '{1'b0, OP_SCAN,      C_SCAN_MORE,    S_SCAN};
      S_ASSIGN:    w = '{1'b0, OP_ASSIGN,    C_PICK_MORE,    S_PICK_INIT};
      S_EMIT_INIT: w = '{1'b0, OP_EMIT_INIT, C_NEVER,        S_IDLE};
      S_EMIT_RD:   w = '{1'b0, OP_EMIT_RD,   C_FLAG_CLEAR,   S_EMIT_NEXT};
      S_EMIT_OUT:  w = '{1'b0, OP_OUT_PAIR,  C_OUT_BUSY,     S_EMIT_OUT};
      S_EMIT_NEXT: w = '{1'b0, OP_K_INC,     C_EMIT_MORE,    S_EMIT_RD};
      S_DONE_CLR:  w = '{1'b0, OP_CLEAR,     C_ALWAYS,       S_IDLE};
      default:     w = '{1'b0, OP_NONE,      C_ALWAYS,       S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/lfrm_ifs.sv
// Input channel: one request word per handshake.
interface lfrm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] symbol;

  modport source (output valid, output req_type, output symbol, input ready);
  modport sink (input valid, input req_type, input symbol, output ready);
endinterface

// Result channel: one (letter, symbol) word per handshake.
interface lfrm_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] letter;
  logic [7:0] mapped_symbol;
  logic       valid_res;
  logic       last;

  modport source (output valid, output letter, output mapped_symbol, output valid_res,
                  output last, input ready);
  modport sink (input valid, input letter, input mapped_symbol, input valid_res,
                input last, output ready);
endinterface

### hw/rtl/lfrm_ucode_seq.sv
`include "letter_frequency_rank_mapper_defines.svh"

module lfrm_ucode_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lfrm_pkg::dp_status_t  status_i,
  output lfrm_pkg::ctrl_word_t  ctrl_o
);
  import lfrm_pkg::*;

  step_t      upc_r;
  step_t      upc_nxt;
  ctrl_word_t ctrl;
  logic       take;

  always_comb begin
    ctrl = ucode_rom(upc_r);
    case (ctrl.cond)
      C_NEVER:        take = 1'b0;
      C_ALWAYS:       take = 1'b1;
      C_NO_ACCEPT:    take = !status_i.accept;
      C_NOT_TEXT:     take = !status_i.is_text;
      C_NOT_TABLE:    take = !status_i.is_table;
      C_NOT_FINISH:   take = !status_i.is_finish;
      C_TAB_NONEMPTY: take = status_i.tab_nonempty;
      C_OUT_BUSY:     take = status_i.out_busy;
      C_SCAN_MORE:    take = status_i.scan_more;
      C_PICK_MORE:    take = status_i.pick_more;
      C_FLAG_CLEAR:   take = !status_i.flag_set;
      C_EMIT_MORE:    take = status_i.emit_more;
      default:        take = 1'b0;
    endcase
    upc_nxt = take ? ctrl.target : step_t'(upc_r + 5'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign ctrl_o = ctrl;

  `LFRM_ASSERT_RST(a_reset_to_idle, !rst_n |=> (upc_r == S_IDLE), "sequencer not idle after reset")
  `LFRM_ASSERT(a_accept_dispatch, (upc_r == S_IDLE && status_i.accept) |=> (upc_r == S_TXT_CHK), "accepted word not dispatched")

endmodule

### hw/rtl/lfrm_datapath.sv
`include "letter_frequency_rank_mapper_defines.svh"

module lfrm_datapath #(
  parameter int ALPHABET_SIZE = 26,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lfrm_pkg::ctrl_word_t  ctrl_i,
  output lfrm_pkg::dp_status_t  status_o,
  lfrm_in_if.sink               in_ch,
  lfrm_out_if.source            out_ch
);
  import lfrm_pkg::*;

  localparam int IDX_W = $clog2(ALPHABET_SIZE);
  localparam int LEN_W = $clog2(ALPHABET_SIZE + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHABET_SIZE - 1);
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(ALPHABET_SIZE);
  localparam logic [8:0] CODE_END = 9'(32'(CODE_A) + ALPHABET_SIZE);

  // Storage.
  logic [COUNT_WIDTH-1:0] cnt_mem [ALPHABET_SIZE];
  logic [7:0]             tab_mem [ALPHABET_SIZE];
  logic [7:0]             asg_mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] cnt_vld_r;
  logic [ALPHABET_SIZE-1:0] asg_flag_r;
  logic [LEN_W-1:0]       tab_len_r;

  // Working registers.
  logic [1:0]             req_r;
  logic [7:0]             sym_r;
  logic [IDX_W-1:0]       j_r;
  logic [IDX_W-1:0]       k_r;
  logic [IDX_W-1:0]       n_r;
  logic [IDX_W-1:0]       best_r;
  logic [COUNT_WIDTH-1:0] best_cnt_r;
  logic                   have_best_r;
  logic [COUNT_WIDTH-1:0] cnt_rdata_r;
  logic                   cnt_rvld_r;
  logic [7:0]             tab_rdata_r;
  logic [7:0]             asg_rdata_r;

  // Result register.
  logic       out_valid_r;
  logic [6:0] out_letter_r;
  logic [7:0] out_sym_r;
  logic       out_vres_r;
  logic       out_last_r;

  logic                   accept;
  logic                   in_range;
  logic [7:0]             sym_off;
  logic [IDX_W-1:0]       sym_idx;
  logic                   cnt_ren;
  logic [IDX_W-1:0]       cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   better;
  logic                   out_free;
  logic                   out_load;
  logic [7:0]             letter_code;
  logic                   is_last;

  assign in_ch.ready = ctrl_i.in_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign in_range = ({1'b0, sym_r} >= {1'b0, CODE_A}) && ({1'b0, sym_r} < CODE_END);
  assign sym_off  = sym_r - CODE_A;
  assign sym_idx  = sym_off[IDX_W-1:0];

  // A count whose valid bit is clear reads as zero.
  assign cnt_cur = cnt_rvld_r ? cnt_rdata_r : '0;
  assign cnt_inc = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);
  assign better  = !asg_flag_r[k_r] && (!have_best_r || (cnt_cur > best_cnt_r));

  assign out_free    = !out_valid_r || out_ch.ready;
  assign out_load    = out_free && (ctrl_i.op == OP_OUT_EMPTY || ctrl_i.op == OP_OUT_PAIR);
  assign letter_code = CODE_A + 8'(k_r);
  assign is_last     = (LEN_W'(n_r) + LEN_W'(1)) == tab_len_r;

  always_comb begin
    cnt_ren   = 1'b0;
    cnt_raddr = '0;
    case (ctrl_i.op)
      OP_CNT_RD: begin
        cnt_ren   = in_range;
        cnt_raddr = sym_idx;
      end
      OP_SCAN_INIT: begin
        cnt_ren   = 1'b1;
        cnt_raddr = '0;
      end
      OP_SCAN: begin
        cnt_ren   = (k_r != LAST_IDX);
        cnt_raddr = k_r + IDX_W'(1);
      end
      default: begin
        cnt_ren   = 1'b0;
        cnt_raddr = '0;
      end
    endcase
  end

  always_comb begin
    status_o.accept       = accept;
    status_o.is_text      = (req_r == REQ_TEXT);
    status_o.is_table     = (req_r == REQ_TABLE);
    status_o.is_finish    = (req_r == REQ_FINISH);
    status_o.tab_nonempty = (tab_len_r != '0);
    status_o.out_busy     = !out_free;
    status_o.scan_more    = (k_r != LAST_IDX);
    status_o.pick_more    = (LEN_W'(j_r) + LEN_W'(1)) < tab_len_r;
    status_o.flag_set     = asg_flag_r[k_r];
    status_o.emit_more    = (k_r != LAST_IDX);
  end

  // Memories and their registered read ports.
  always_ff @(posedge clk) begin
    if (ctrl_i.op == OP_CNT_INC && in_range) begin
      cnt_mem[sym_idx] <= cnt_inc;
    end
    if (cnt_ren) begin
      cnt_rdata_r <= cnt_mem[cnt_raddr];
      cnt_rvld_r  <= cnt_vld_r[cnt_raddr];
    end
    if (ctrl_i.op == OP_TAB_WR && tab_len_r < FULL_LEN) begin
      tab_mem[tab_len_r[IDX_W-1:0]] <= sym_r;
    end
    if (ctrl_i.op == OP_SCAN_INIT) begin
      tab_rdata_r <= tab_mem[j_r];
    end
    if (ctrl_i.op == OP_ASSIGN) begin
      asg_mem[best_r] <= tab_rdata_r;
    end
    if (ctrl_i.op == OP_EMIT_RD) begin
      asg_rdata_r <= asg_mem[k_r];
    end
  end

  // Control state: valid bits, flags, table length and the pick counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r  <= '0;
      asg_flag_r <= '0;
      tab_len_r  <= '0;
      j_r        <= '0;
    end else begin
      unique case (ctrl_i.op)
        OP_CNT_INC: begin
          if (in_range) begin
            cnt_vld_r[sym_idx] <= 1'b1;
          end
        end
        OP_TAB_WR: begin
          if (tab_len_r < FULL_LEN) begin
            tab_len_r <= tab_len_r + LEN_W'(1);
          end
        end
        OP_ASSIGN: begin
          asg_flag_r[best_r] <= 1'b1;
          cnt_vld_r[best_r]  <= 1'b0;
          j_r                <= j_r + IDX_W'(1);
        end
        OP_CLEAR: begin
          cnt_vld_r  <= '0;
          asg_flag_r <= '0;
          tab_len_r  <= '0;
          j_r        <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers set up by the program before use.
  always_ff @(posedge clk) begin
    unique case (ctrl_i.op)
      OP_LATCH: begin
        if (accept) begin
          req_r <= in_ch.req_type;
          sym_r <= in_ch.symbol;
        end
      end
      OP_SCAN_INIT: begin
        k_r         <= '0;
        have_best_r <= 1'b0;
      end
      OP_SCAN: begin
        if (better) begin
          best_r      <= k_r;
          best_cnt_r  <= cnt_cur;
          have_best_r <= 1'b1;
        end
        k_r <= k_r + IDX_W'(1);
      end
      OP_EMIT_INIT: begin
        k_r <= '0;
        n_r <= '0;
      end
      OP_OUT_PAIR: begin
        if (out_free) begin
          n_r <= n_r + IDX_W'(1);
        end
      end
      OP_K_INC: begin
        k_r <= k_r + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (ctrl_i.op == OP_OUT_PAIR) begin
        out_letter_r <= letter_code[6:0];
        out_sym_r    <= asg_rdata_r;
        out_vres_r   <= 1'b1;
        out_last_r   <= is_last;
      end else begin
        out_letter_r <= '0;
        out_sym_r    <= '0;
        out_vres_r   <= 1'b0;
        out_last_r   <= 1'b1;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.letter        = out_letter_r;
  assign out_ch.mapped_symbol = out_sym_r;
  assign out_ch.valid_res     = out_vres_r;
  assign out_ch.last          = out_last_r;

  `LFRM_ASSERT(a_assign_fresh, (ctrl_i.op == OP_ASSIGN) |-> (have_best_r && !asg_flag_r[best_r]), "symbol assigned to a taken letter")
  `LFRM_ASSERT(a_clear_all, (ctrl_i.op == OP_CLEAR) |=> (asg_flag_r == '0 && cnt_vld_r == '0 && tab_len_r == '0), "state not cleared after finish")
  `LFRM_ASSERT(a_emit_flagged, (ctrl_i.op == OP_OUT_PAIR && out_free) |-> asg_flag_r[k_r], "pair emitted for an unassigned letter")

endmodule

### hw/rtl/letter_frequency_rank_mapper.sv
// Letter frequency rank mapper. Each input word is a text character, a table
// symbol or a finish request. Text characters A to Z (ALPHABET_SIZE letters
// from 'A') are counted into saturating COUNT_WIDTH-bit counters; any other
// character is ignored. Table symbols are appended to an ordered table of up
// to ALPHABET_SIZE entries, and later ones are dropped. On finish the block
// walks the table in order and gives each symbol to the not yet assigned
// letter with the highest count, the lowest letter winning ties, then sends
// one result word per assigned letter in letter order with last set on the
// final word, and clears all counts and the table. A finish with an empty
// table sends a single word with valid_res low and last high. The block is
// run by a microprogram and takes one input word at a time; it is ready only
// while the program sits in its idle step. Dispatch steps test the request
// type one after another, and a text word then reads and writes back its
// counter. On finish, each table entry takes a setup step, one full pass
// over the counter memory at one counter per cycle and an assign step, and
// the result pass reads and tests each letter in turn and sends a word for
// each assigned one, waiting while the result side stalls. Counts are
// cleared at reset and after each finish through per-letter valid bits, so
// no clearing pass is needed.
module letter_frequency_rank_mapper #(
  parameter int ALPHABET_SIZE = 26,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  lfrm_in_if.sink     in_ch,
  lfrm_out_if.source  out_ch
);
  import lfrm_pkg::*;

  // Control word from the sequencer and status back from the datapath.
  ctrl_word_t ctrl;
  dp_status_t status;

  lfrm_ucode_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // Counter, table and assignment memories plus the result register.
  lfrm_datapath #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl_i   (ctrl),
    .status_o (status),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

endmodule
